[src/tdi_pkg.sv]
// ----------------------------------------------------------------------------
// Tilt direction indicator package
// Shared widths, fixed-point constants, direction and register codes, and the
// arctangent table of the CORDIC unit.
// ----------------------------------------------------------------------------
package tdi_pkg;

    // Sample averaging
    localparam int AVG_COUNT = 8;
    localparam int SAMPLE_W  = 14;
    localparam int CNT_W     = $clog2(AVG_COUNT);
    localparam int SUM_W     = SAMPLE_W + CNT_W;

    // CORDIC datapath
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int PRESCALE     = 24;
    localparam int CW           = SUM_W + PRESCALE + 3;
    localparam int ZW           = 24;
    localparam int ATAN_W       = 22;
    localparam int ANG_W        = 23;
    localparam int DEG90_FX     = 90 * 65536;

    // Angle and result fields
    localparam int ANGLE_W = 17;
    localparam int FULL_W  = ANGLE_W + 8;
    localparam int DIR_W   = 3;
    localparam int DUTY_W  = 16;
    localparam int DIFF_W  = 15;
    localparam int LIM_W   = ANGLE_W + 1;
    localparam int QUAD_T  = 90 * 256;

    // Configuration field widths
    localparam int THR_W    = 7;
    localparam int TOL_W    = 13;
    localparam int PERIOD_W = 16;
    localparam int SPLIT_W  = 7;

    // Duty scaling: divide by 90*256 = 2^9 * 45, the odd part by reciprocal.
    localparam int DIV_SHIFT   = 9;
    localparam int DIV_ODD     = 45;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP       = (2 ** RECIP_SHIFT + DIV_ODD - 1) / DIV_ODD;
    localparam int MUL_A_W     = 22;
    localparam int MUL_B_W     = 23;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;

    // Stream widths
    localparam int S_DATA_W = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int M_BITS   = DIR_W + ANGLE_W + DUTY_W + 1;
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_NORTH = 3'd0;
    localparam logic [DIR_W-1:0] DIR_EAST  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd2;
    localparam logic [DIR_W-1:0] DIR_WEST  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_FLAT  = 3'd4;

    // Register map
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_THRESHOLD = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_X_TOLERANCE     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_Y_TOLERANCE     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PWM_PERIOD      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TONE_SPLIT      = 3'd4;

    // atan(2^-i) in degrees, units of 2^-16, rounded.
    function automatic logic [ATAN_W-1:0] atan_entry(input int unsigned idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            0:  val = ATAN_W'(2949120);
            1:  val = ATAN_W'(1740967);
            2:  val = ATAN_W'(919879);
            3:  val = ATAN_W'(466945);
            4:  val = ATAN_W'(234379);
            5:  val = ATAN_W'(117304);
            6:  val = ATAN_W'(58666);
            7:  val = ATAN_W'(29335);
            8:  val = ATAN_W'(14668);
            9:  val = ATAN_W'(7334);
            10: val = ATAN_W'(3667);
            11: val = ATAN_W'(1833);
            12: val = ATAN_W'(917);
            13: val = ATAN_W'(458);
            14: val = ATAN_W'(229);
            15: val = ATAN_W'(115);
            16: val = ATAN_W'(57);
            17: val = ATAN_W'(29);
            18: val = ATAN_W'(14);
            19: val = ATAN_W'(7);
            20: val = ATAN_W'(4);
            21: val = ATAN_W'(2);
            22: val = ATAN_W'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

[src/tdi_cordic.sv]
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// First-quadrant atan2 of two magnitudes, one rotation per cycle through a
// single shift/add unit; result in degrees, units of 2^-16, clamped 0..90.
// ----------------------------------------------------------------------------
module tdi_cordic import tdi_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] abs_x,
    input  logic [SUM_W-1:0] abs_y,
    output logic             done,
    output logic [ANG_W-1:0] angle
);

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [CW-1:0] x_shr, y_shr;
    logic signed [ZW-1:0] z_reg, z_next, atan_val;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    // Arithmetic shifts round toward minus infinity, as the rotation needs.
    assign x_shr    = x_reg >>> step_reg;
    assign y_shr    = y_reg >>> step_reg;
    assign atan_val = $signed(ZW'(atan_entry(int'(step_reg))));

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = $signed(CW'({abs_x, {PRESCALE{1'b0}}}));
            y_next    = $signed(CW'({abs_y, {PRESCALE{1'b0}}}));
            z_next    = '0;
            step_next = '0;
            busy_next = 1'b0;
            // Axis-aligned vectors skip the rotations.
            if (abs_y == '0) begin
                done_next = 1'b1;
            end else if (abs_x == '0) begin
                z_next    = ZW'(DEG90_FX);
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (y_reg > 0) begin
                x_next = x_reg + y_shr;
                y_next = y_reg - x_shr;
                z_next = z_reg + atan_val;
            end else begin
                x_next = x_reg - y_shr;
                y_next = y_reg + x_shr;
                z_next = z_reg - atan_val;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    always_comb begin
        if (z_reg < 0) begin
            angle = '0;
        end else if (z_reg > $signed(ZW'(DEG90_FX))) begin
            angle = ANG_W'(DEG90_FX);
        end else begin
            angle = z_reg[ANG_W-1:0];
        end
    end

    assign done = done_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start)
        else $error("CORDIC started while busy");

endmodule

[src/tilt_direction_indicator.sv]
// ----------------------------------------------------------------------------
// Tilt direction indicator
// Sums blocks of accelerometer samples, finds the tilt angle with a CORDIC
// and gives direction, angle, PWM duty and tone choice once per block.
// ----------------------------------------------------------------------------
//  Channel | Ports      | Direction | Beat
//  --------+------------+-----------+-------------------------------------
//  input   | s_t*       | in        | one x/y sample pair
//  result  | m_t*       | out       | one result per block of 8 samples
//  config  | APB p*     | in/out    | register write or read
//
//  A sample that does not close a block leaves s_tready high.
//  The closing sample holds s_tready low while the block is processed: a
//  setup state, 16 CORDIC rotations in the shared shift/add unit (skipped
//  when one sum is zero) and a state that flags their end, then classify,
//  two passes through the shared multiplier and output load. The result
//  register decouples the output; a stalled m_tready delays the load of
//  the next result and holds s_tready low. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module tilt_direction_indicator import tdi_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // x_sample[13:0], y_sample[27:14]
    output logic                m_tvalid,
    input  logic                m_tready,
    // direction[2:0], tilt_angle[19:3], duty[35:20], tone_select[36]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [0:0]          m_tuser,   // duty_valid[0]
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_CLASS = 3'd3;
    localparam logic [2:0] ST_MUL1  = 3'd4;
    localparam logic [2:0] ST_MUL2  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    // Configuration registers
    logic [THR_W-1:0]    thr_reg;
    logic [TOL_W-1:0]    xtol_reg, ytol_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [SPLIT_W-1:0]  split_reg;
    logic                cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= THR_W'(10);
            xtol_reg   <= TOL_W'(45);
            ytol_reg   <= TOL_W'(34);
            period_reg <= PERIOD_W'(39);
            split_reg  <= SPLIT_W'(45);
        end else if (cfg_write) begin
            case (reg_idx)
                REG_ANGLE_THRESHOLD: thr_reg    <= pwdata[THR_W-1:0];
                REG_X_TOLERANCE:     xtol_reg   <= pwdata[TOL_W-1:0];
                REG_Y_TOLERANCE:     ytol_reg   <= pwdata[TOL_W-1:0];
                REG_PWM_PERIOD:      period_reg <= pwdata[PERIOD_W-1:0];
                REG_TONE_SPLIT:      split_reg  <= pwdata[SPLIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ANGLE_THRESHOLD: prdata = 32'(thr_reg);
            REG_X_TOLERANCE:     prdata = 32'(xtol_reg);
            REG_Y_TOLERANCE:     prdata = 32'(ytol_reg);
            REG_PWM_PERIOD:      prdata = 32'(period_reg);
            REG_TONE_SPLIT:      prdata = 32'(split_reg);
            default:             prdata = '0;
        endcase
    end

    // Control and datapath registers
    logic [2:0]                state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [SUM_W-1:0]   xs_reg, ys_reg, xs_add, ys_add;
    logic [SUM_W-1:0]          abs_x, abs_y;
    logic [SUM_W:0]            xlim, ylim;
    logic                      xneg_reg, yneg_reg, flat_reg;
    logic [ANGLE_W-1:0]        t_reg;
    logic [FULL_W-1:0]         full_val;
    logic [DIR_W-1:0]          dir_reg, dir_calc;
    logic [DIFF_W-1:0]         diff_reg, diff_calc;
    logic [MUL_A_W-1:0]        mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic [PROD_W-1:0]         mul_p, prod_reg;
    logic                      s_accept, block_end, out_free;
    logic                      cordic_done;
    logic [ANG_W-1:0]          cordic_angle;

    // Result register
    logic                      m_valid_reg;
    logic [DIR_W-1:0]          dir_out;
    logic [ANGLE_W-1:0]        t_out;
    logic [DUTY_W-1:0]         duty_out;
    logic                      dv_out, tone_out;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign block_end = (cnt_reg == CNT_W'(AVG_COUNT - 1));
    assign out_free  = !m_valid_reg || m_tready;

    assign xs_add = xs_reg + SUM_W'($signed(s_tdata[SAMPLE_W-1:0]));
    assign ys_add = ys_reg + SUM_W'($signed(s_tdata[2*SAMPLE_W-1:SAMPLE_W]));

    assign abs_x = xs_reg[SUM_W-1] ? SUM_W'(-xs_reg) : SUM_W'(xs_reg);
    assign abs_y = ys_reg[SUM_W-1] ? SUM_W'(-ys_reg) : SUM_W'(ys_reg);
    assign xlim  = (SUM_W+1)'(xtol_reg) * (SUM_W+1)'(AVG_COUNT);
    assign ylim  = (SUM_W+1)'(ytol_reg) * (SUM_W+1)'(AVG_COUNT);

    tdi_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_PREP),
        .abs_x   (abs_x),
        .abs_y   (abs_y),
        .done    (cordic_done),
        .angle   (cordic_angle)
    );

    // Map the first-quadrant angle by the signs of the sums.
    always_comb begin
        case ({xneg_reg, yneg_reg})
            2'b00:   full_val = FULL_W'(cordic_angle);
            2'b10:   full_val = FULL_W'(2 * DEG90_FX) - FULL_W'(cordic_angle);
            2'b11:   full_val = FULL_W'(2 * DEG90_FX) + FULL_W'(cordic_angle);
            default: full_val = FULL_W'(4 * DEG90_FX) - FULL_W'(cordic_angle);
        endcase
        if (full_val >= FULL_W'(4 * DEG90_FX)) begin
            full_val = full_val - FULL_W'(4 * DEG90_FX);
        end
    end

    // Quadrant pick; the lowest matching quadrant wins.
    always_comb begin : classify
        logic [LIM_W-1:0] lo_v, hi_v;
        lo_v      = '0;
        hi_v      = '0;
        dir_calc  = DIR_FLAT;
        diff_calc = '0;
        if (!flat_reg) begin
            for (int k = 3; k >= 0; k--) begin
                lo_v = LIM_W'((k * 90 + int'(thr_reg)) * 256);
                hi_v = LIM_W'((k + 1) * QUAD_T);
                if (LIM_W'(t_reg) >= lo_v && LIM_W'(t_reg) <= hi_v) begin
                    dir_calc  = DIR_W'(k);
                    diff_calc = DIFF_W'(hi_v - LIM_W'(t_reg));
                end
            end
        end
    end

    // Shared multiplier: diff * period, then scaling by the reciprocal of 45.
    always_comb begin
        if (state_reg == ST_MUL1) begin
            mul_a = MUL_A_W'(diff_reg);
            mul_b = MUL_B_W'(period_reg);
        end else begin
            mul_a = prod_reg[DIV_SHIFT +: MUL_A_W];
            mul_b = MUL_B_W'(RECIP);
        end
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_accept && block_end) state_next = ST_PREP;
            ST_PREP:  state_next = ST_WAIT;
            ST_WAIT:  if (cordic_done) state_next = ST_CLASS;
            ST_CLASS: state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_EMIT;
            ST_EMIT:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            xs_reg      <= '0;
            ys_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_accept) begin
                xs_reg  <= xs_add;
                ys_reg  <= ys_add;
                cnt_reg <= block_end ? '0 : cnt_reg + 1'b1;
            end else if (state_reg == ST_PREP) begin
                xs_reg <= '0;
                ys_reg <= '0;
            end
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_PREP) begin
            xneg_reg <= xs_reg[SUM_W-1];
            yneg_reg <= ys_reg[SUM_W-1];
            // Strictly inside +-(count * tolerance) on both axes.
            flat_reg <= ({1'b0, abs_x} < xlim) && ({1'b0, abs_y} < ylim);
        end
        if (state_reg == ST_WAIT && cordic_done) begin
            t_reg <= full_val[FULL_W-1:8];
        end
        if (state_reg == ST_CLASS) begin
            dir_reg  <= dir_calc;
            diff_reg <= diff_calc;
        end
        if (state_reg == ST_MUL1 || state_reg == ST_MUL2) begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_EMIT && out_free) begin
            dir_out  <= dir_reg;
            t_out    <= t_reg;
            duty_out <= prod_reg[RECIP_SHIFT +: DUTY_W];
            dv_out   <= (dir_reg != DIR_FLAT);
            tone_out <= (diff_reg > DIFF_W'({split_reg, 8'b0}));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({tone_out, duty_out, t_out, dir_out});
    assign m_tuser  = dv_out;

    a_cordic_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_done |-> state_reg == ST_WAIT)
        else $error("CORDIC result arrived outside the wait state");

    a_count_clear_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> cnt_reg == '0)
        else $error("sample count not cleared while a block is processed");

    a_block_end_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && block_end |=> state_reg == ST_PREP)
        else $error("closing beat of a block did not start processing");

    a_flat_no_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && dir_out == DIR_FLAT |-> duty_out == '0 && !dv_out && !tone_out)
        else $error("flat result carries duty or tone");

endmodule
